>>> hdl/ivan_pkg.sv
`timescale 1ns / 1ps
package ivan_pkg;

  localparam int unsigned CordicIters = 30;
  localparam logic signed [33:0] CordicK = 34'sd652032874;
  localparam logic signed [33:0] Q30Pi = 34'sd3373259426;
  localparam logic signed [33:0] Q30HalfPi = 34'sd1686629713;

  typedef enum logic [2:0] {
    REG_ACCEL_LIMIT = 3'd0,
    REG_COEF_B0     = 3'd1,
    REG_COEF_A1     = 3'd2,
    REG_COEF_A2     = 3'd3,
    REG_GRAVITY     = 3'd4,
    REG_INV_DT      = 3'd5
  } ivan_reg_e;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CORE = 5'b00010,
    S_ROT  = 5'b00100,
    S_NORM = 5'b01000,
    S_DONE = 5'b10000
  } ivan_state_e;

  // Sequencer step shared by all lanes.
  typedef struct packed {
    logic       run;
    logic [4:0] cnt;
  } ivan_step_t;

  function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
    logic signed [33:0] r;
    begin
      case (idx)
        5'd0: r = 34'sd843314856;
        5'd1: r = 34'sd497837829;
        5'd2: r = 34'sd263043836;
        5'd3: r = 34'sd133525158;
        5'd4: r = 34'sd67021686;
        5'd5: r = 34'sd33543515;
        5'd6: r = 34'sd16775850;
        5'd7: r = 34'sd8388437;
        5'd8: r = 34'sd4194282;
        5'd9: r = 34'sd2097149;
        5'd10: r = 34'sd1048575;
        5'd11: r = 34'sd524287;
        5'd12: r = 34'sd262143;
        5'd13: r = 34'sd131071;
        5'd14: r = 34'sd65535;
        5'd15: r = 34'sd32767;
        5'd16: r = 34'sd16383;
        5'd17: r = 34'sd8191;
        5'd18: r = 34'sd4095;
        5'd19: r = 34'sd2047;
        5'd20: r = 34'sd1023;
        5'd21: r = 34'sd511;
        5'd22: r = 34'sd255;
        5'd23: r = 34'sd127;
        5'd24: r = 34'sd63;
        5'd25: r = 34'sd31;
        5'd26: r = 34'sd15;
        5'd27: r = 34'sd8;
        5'd28: r = 34'sd4;
        5'd29: r = 34'sd2;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction

endpackage

>>> hdl/ivan_biquad_lane.sv
`timescale 1ns / 1ps
module ivan_biquad_lane import ivan_pkg::*; #(
  parameter int unsigned SatBits = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ivan_step_t         step_i,
  input  logic signed [31:0] acc_i,
  input  logic [30:0]        limit_i,
  input  logic signed [31:0] b0_i,
  input  logic signed [31:0] a1_i,
  input  logic signed [31:0] a2_i,
  output logic signed [31:0] f_o
);

  localparam logic signed [67:0] SatHi = (68'sd1 <<< (SatBits - 1)) - 68'sd1;
  localparam logic signed [67:0] SatLo = -SatHi - 68'sd1;

  logic signed [31:0] x_q, d1_q, d2_q, y1_q, y2_q;
  logic signed [63:0] prod_q;
  logic signed [67:0] acc_q;
  logic signed [31:0] lim, x_clamp, op_a, op_b, f_sat;
  logic signed [67:0] term, rnd;

  always_comb begin
    lim = $signed({1'b0, limit_i});
    if (acc_i > lim) begin
      x_clamp = lim;
    end else if (acc_i < -lim) begin
      x_clamp = -lim;
    end else begin
      x_clamp = acc_i;
    end

    case (step_i.cnt)
      5'd2: begin op_a = b0_i; op_b = d1_q; end
      5'd3: begin op_a = b0_i; op_b = d2_q; end
      5'd4: begin op_a = a1_i; op_b = y1_q; end
      5'd5: begin op_a = a2_i; op_b = y2_q; end
      default: begin op_a = b0_i; op_b = x_q; end
    endcase

    // Term issued last cycle: middle tap doubles, feedback taps subtract.
    term = 68'(prod_q);
    if (step_i.cnt == 5'd3) begin
      term = term <<< 1;
    end else if (step_i.cnt == 5'd5 || step_i.cnt == 5'd6) begin
      term = -term;
    end

    rnd = (acc_q + 68'sd536870912) >>> 30;
    if (rnd > SatHi) begin
      f_sat = SatHi[31:0];
    end else if (rnd < SatLo) begin
      f_sat = SatLo[31:0];
    end else begin
      f_sat = rnd[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i.run) begin
      if (step_i.cnt == 5'd0) begin
        x_q <= x_clamp;
      end
      if (step_i.cnt >= 5'd1 && step_i.cnt <= 5'd5) begin
        prod_q <= op_a * op_b;
      end
      if (step_i.cnt == 5'd1) begin
        acc_q <= '0;
      end else if (step_i.cnt >= 5'd2 && step_i.cnt <= 5'd6) begin
        acc_q <= acc_q + term;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_q <= '0;
      d2_q <= '0;
      y1_q <= '0;
      y2_q <= '0;
    end else if (step_i.run && step_i.cnt == 5'd7) begin
      d2_q <= d1_q;
      d1_q <= x_q;
      y2_q <= y1_q;
      y1_q <= f_sat;
    end
  end

  assign f_o = y1_q;

endmodule

>>> hdl/ivan_cordic.sv
`timescale 1ns / 1ps
module ivan_cordic import ivan_pkg::*; (
  input  logic               clk_i,
  input  ivan_step_t         step_i,
  input  logic signed [18:0] angle_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  logic signed [33:0] x_q, y_q, z_q;
  logic               neg_q;
  logic signed [33:0] z0, xs, ys;
  logic [4:0]         idx;

  always_comb begin
    z0 = 34'(angle_i) <<< 14;
    idx = step_i.cnt - 5'd1;
    xs = x_q >>> idx;
    ys = y_q >>> idx;
  end

  always_ff @(posedge clk_i) begin
    if (step_i.run) begin
      if (step_i.cnt == 5'd0) begin
        // Fold the angle into [-pi/2, pi/2]; flip both outputs if folded.
        x_q <= CordicK;
        y_q <= '0;
        if (z0 > Q30HalfPi) begin
          z_q <= z0 - Q30Pi;
          neg_q <= 1'b1;
        end else if (z0 < -Q30HalfPi) begin
          z_q <= z0 + Q30Pi;
          neg_q <= 1'b1;
        end else begin
          z_q <= z0;
          neg_q <= 1'b0;
        end
      end else if (step_i.cnt <= 5'(CordicIters)) begin
        if (z_q >= 0) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_q30(idx);
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_q30(idx);
        end
      end
    end
  end

  assign sin_o = neg_q ? -y_q[31:0] : y_q[31:0];
  assign cos_o = neg_q ? -x_q[31:0] : x_q[31:0];

endmodule

>>> hdl/ivan_norm_lane.sv
`timescale 1ns / 1ps
module ivan_norm_lane import ivan_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ivan_step_t         step_i,
  input  logic signed [31:0] value_i,
  output logic signed [17:0] norm_o
);

  logic [31:0] peak_q;
  logic [31:0] rem_q;
  logic [16:0] quo_q;
  logic        neg_q;
  logic [31:0] mag, peak_new;
  logic [47:0] num;
  logic [32:0] trial;
  logic        bit_set;

  always_comb begin
    mag = value_i[31] ? 32'(-33'(value_i)) : 32'(value_i);
    peak_new = (mag > peak_q) ? mag : peak_q;
    num = {mag, 16'd0} + 48'(peak_new >> 1);
    trial = {rem_q, quo_q[16]};
    bit_set = (trial >= {1'b0, peak_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= 32'd65536;
    end else if (step_i.run && step_i.cnt == 5'd0) begin
      peak_q <= peak_new;
    end
  end

  // Restoring division, one quotient bit per step; numerator bits shift out
  // of quo_q as quotient bits shift in.
  always_ff @(posedge clk_i) begin
    if (step_i.run) begin
      if (step_i.cnt == 5'd0) begin
        rem_q <= {1'b0, num[47:17]};
        quo_q <= num[16:0];
        neg_q <= value_i[31];
      end else if (step_i.cnt <= 5'd17) begin
        rem_q <= bit_set ? 32'(trial - {1'b0, peak_q}) : trial[31:0];
        quo_q <= {quo_q[15:0], bit_set};
      end
    end
  end

  assign norm_o = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

>>> hdl/imu_vertical_accel_normalizer.sv
`timescale 1ns / 1ps
// Channel | Handshake              | Payload
// in      | in_valid_i / in_stall_o | acc_x/y/z, roll, pitch, vel_z, hip_pos, knee_pos
// out     | out_valid_o/out_stall_i | norm_accel_z, norm_vel_z, norm_hip, norm_knee,
//         |                         | norm_accel_rate
// cfg     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A beat passes from acceptance to a loaded result through, in order: the
// biquad lanes and CORDIC lanes side by side (the 30 CORDIC iterations set
// how long this runs), the shared rotation multiplier, the five
// restoring-division lanes, and the load of the output register.
// in_stall_o is high while a beat is in flight; a finished result waits in
// the output register, so the next input beat is taken while it is stalled.
// Reset clears filter state, previous vertical value, peaks (to 1.0) and
// registers to their defaults.
module imu_vertical_accel_normalizer import ivan_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] acc_x_i,
  input  logic signed [31:0] acc_y_i,
  input  logic signed [31:0] acc_z_i,
  input  logic signed [18:0] roll_i,
  input  logic signed [18:0] pitch_i,
  input  logic signed [31:0] vel_z_i,
  input  logic signed [31:0] hip_pos_i,
  input  logic signed [31:0] knee_pos_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [17:0] norm_accel_z_o,
  output logic signed [17:0] norm_vel_z_o,
  output logic signed [17:0] norm_hip_o,
  output logic signed [17:0] norm_knee_o,
  output logic signed [17:0] norm_accel_rate_o
);

  localparam int unsigned SatBits = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam logic signed [67:0] SatHi = (68'sd1 <<< (SatBits - 1)) - 68'sd1;
  localparam logic signed [67:0] SatLo = -SatHi - 68'sd1;

  // Configuration registers
  logic [30:0]        limit_q, gravity_q, inv_dt_q;
  logic signed [31:0] b0_q, a1_q, a2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= 31'd1310720;
      b0_q      <= 32'sd6743;
      a1_q      <= -32'sd1947914299;
      a2_q      <= 32'sd885941229;
      gravity_q <= 31'd642908;
      inv_dt_q  <= 31'd65536000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ACCEL_LIMIT: limit_q   <= cfg_data_i[30:0];
        REG_COEF_B0:     b0_q      <= cfg_data_i;
        REG_COEF_A1:     a1_q      <= cfg_data_i;
        REG_COEF_A2:     a2_q      <= cfg_data_i;
        REG_GRAVITY:     gravity_q <= cfg_data_i[30:0];
        REG_INV_DT:      inv_dt_q  <= cfg_data_i[30:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // Sequencer
  ivan_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        in_fire, out_load;
  logic        out_valid_q;

  assign in_fire = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q + 5'd1;
    unique case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (in_fire) state_d = S_CORE;
      end
      S_CORE: begin
        if (cnt_q == 5'd31) begin
          state_d = S_ROT;
          cnt_d = '0;
        end
      end
      S_ROT: begin
        if (cnt_q == 5'd8) begin
          state_d = S_NORM;
          cnt_d = '0;
        end
      end
      S_NORM: begin
        if (cnt_q == 5'd17) begin
          state_d = S_DONE;
          cnt_d = '0;
        end
      end
      S_DONE: begin
        cnt_d = '0;
        if (out_load) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
        cnt_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end

  // Hold the accepted beat
  logic signed [31:0] ax_q, ay_q, az_q, vel_q, hip_q, knee_q;
  logic signed [18:0] roll_q, pitch_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ax_q <= acc_x_i;
      ay_q <= acc_y_i;
      az_q <= acc_z_i;
      roll_q <= roll_i;
      pitch_q <= pitch_i;
      vel_q <= vel_z_i;
      hip_q <= hip_pos_i;
      knee_q <= knee_pos_i;
    end
  end

  // Filter and trig lanes
  ivan_step_t core_step, norm_step;
  assign core_step = '{run: (state_q == S_CORE), cnt: cnt_q};
  assign norm_step = '{run: (state_q == S_NORM), cnt: cnt_q};

  logic signed [31:0] f0, f1, f2, sr, cr, sp, cp;

  ivan_biquad_lane #(.SatBits(SatBits)) u_lane_x (
    .clk_i, .rst_ni, .step_i(core_step), .acc_i(ax_q), .limit_i(limit_q),
    .b0_i(b0_q), .a1_i(a1_q), .a2_i(a2_q), .f_o(f0)
  );
  ivan_biquad_lane #(.SatBits(SatBits)) u_lane_y (
    .clk_i, .rst_ni, .step_i(core_step), .acc_i(ay_q), .limit_i(limit_q),
    .b0_i(b0_q), .a1_i(a1_q), .a2_i(a2_q), .f_o(f1)
  );
  ivan_biquad_lane #(.SatBits(SatBits)) u_lane_z (
    .clk_i, .rst_ni, .step_i(core_step), .acc_i(az_q), .limit_i(limit_q),
    .b0_i(b0_q), .a1_i(a1_q), .a2_i(a2_q), .f_o(f2)
  );

  ivan_cordic u_cordic_roll (
    .clk_i, .step_i(core_step), .angle_i(roll_q), .sin_o(sr), .cos_o(cr)
  );
  ivan_cordic u_cordic_pitch (
    .clk_i, .step_i(core_step), .angle_i(pitch_q), .sin_o(sp), .cos_o(cp)
  );

  // Rotation, gravity and derivative on one shared multiplier
  logic signed [32:0] op_a, op_b, dv;
  logic signed [65:0] prod_q;
  logic signed [67:0] acc_q, wz_full, dr_full;
  logic signed [31:0] cpsr_q, cpcr_q, wz_q, prev_q, rate_q, prod_rnd, wz_sat, dr_sat;

  always_comb begin
    dv = 33'(wz_q) - 33'(prev_q);
    case (cnt_q)
      5'd0: begin op_a = 33'(cp); op_b = 33'(sr); end
      5'd1: begin op_a = 33'(cp); op_b = 33'(cr); end
      5'd2: begin op_a = 33'(sp); op_b = 33'(f0); end
      5'd3: begin op_a = 33'(cpsr_q); op_b = 33'(f1); end
      5'd4: begin op_a = 33'(cpcr_q); op_b = 33'(f2); end
      default: begin op_a = dv; op_b = $signed({2'b00, inv_dt_q}); end
    endcase

    prod_rnd = 32'((prod_q + 66'sd536870912) >>> 30);

    wz_full = ((acc_q + 68'sd536870912) >>> 30) - $signed({37'd0, gravity_q});
    if (wz_full > SatHi) wz_sat = SatHi[31:0];
    else if (wz_full < SatLo) wz_sat = SatLo[31:0];
    else wz_sat = wz_full[31:0];

    dr_full = (68'(prod_q) + 68'sd32768) >>> 16;
    if (dr_full > SatHi) dr_sat = SatHi[31:0];
    else if (dr_full < SatLo) dr_sat = SatLo[31:0];
    else dr_sat = dr_full[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_ROT) begin
      if (cnt_q <= 5'd4 || cnt_q == 5'd7) prod_q <= op_a * op_b;
      if (cnt_q == 5'd1) cpsr_q <= prod_rnd;
      if (cnt_q == 5'd2) begin
        cpcr_q <= prod_rnd;
        acc_q <= '0;
      end
      if (cnt_q == 5'd3) acc_q <= acc_q - 68'(prod_q);
      if (cnt_q == 5'd4 || cnt_q == 5'd5) acc_q <= acc_q + 68'(prod_q);
      if (cnt_q == 5'd6) wz_q <= wz_sat;
      if (cnt_q == 5'd8) rate_q <= dr_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (state_q == S_ROT && cnt_q == 5'd7) begin
      prev_q <= wz_q;
    end
  end

  // Normalization lanes, each with its own running peak
  logic signed [17:0] n_az, n_vel, n_hip, n_knee, n_rate;

  ivan_norm_lane u_norm_az (
    .clk_i, .rst_ni, .step_i(norm_step), .value_i(wz_q), .norm_o(n_az)
  );
  ivan_norm_lane u_norm_vel (
    .clk_i, .rst_ni, .step_i(norm_step), .value_i(vel_q), .norm_o(n_vel)
  );
  ivan_norm_lane u_norm_hip (
    .clk_i, .rst_ni, .step_i(norm_step), .value_i(hip_q), .norm_o(n_hip)
  );
  ivan_norm_lane u_norm_knee (
    .clk_i, .rst_ni, .step_i(norm_step), .value_i(knee_q), .norm_o(n_knee)
  );
  ivan_norm_lane u_norm_rate (
    .clk_i, .rst_ni, .step_i(norm_step), .value_i(rate_q), .norm_o(n_rate)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      norm_accel_z_o <= n_az;
      norm_vel_z_o <= n_vel;
      norm_hip_o <= n_hip;
      norm_knee_o <= n_knee;
      norm_accel_rate_o <= n_rate;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/ivan_checker.sv
`timescale 1ns / 1ps
module ivan_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [17:0] norm_accel_z_o,
  input logic signed [17:0] norm_vel_z_o,
  input logic signed [17:0] norm_hip_o,
  input logic signed [17:0] norm_knee_o,
  input logic signed [17:0] norm_accel_rate_o
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(norm_accel_z_o)
      && $stable(norm_accel_rate_o))
    else $error("stalled result changed");

  // One beat at a time: acceptance closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open after accept");

  // A new result appears only at the end of a beat in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a beat in flight");

  // Normalized values stay within one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> norm_accel_z_o <= 18'sd65536 && norm_accel_z_o >= -18'sd65536
      && norm_accel_rate_o <= 18'sd65536 && norm_accel_rate_o >= -18'sd65536
      && norm_vel_z_o <= 18'sd65536 && norm_vel_z_o >= -18'sd65536
      && norm_hip_o <= 18'sd65536 && norm_hip_o >= -18'sd65536
      && norm_knee_o <= 18'sd65536 && norm_knee_o >= -18'sd65536)
    else $error("normalized value out of range");

endmodule

bind imu_vertical_accel_normalizer ivan_checker u_ivan_checker (.*);
